FILE: hw/rtl/cise_pkg.sv
// ----------------------------------------------------------------------------
// cise_pkg
// Shared types and constants of the 8-bit instruction subset execute block.
// ----------------------------------------------------------------------------
`default_nettype none

package cise_pkg;

    // Depth of the queue between the decode front and the execute back.
    localparam int CISE_QUEUE_DEPTH = 2;

    // Opcode patterns.
    localparam logic [7:0] OPC_NOP      = 8'h00;
    localparam logic [7:0] OPC_JP_IMM16 = 8'hC3;
    localparam logic [7:0] OPC_XOR_MASK = 8'hF8;
    localparam logic [7:0] OPC_XOR_PAT  = 8'hA8;
    localparam logic [3:0] OPC_LO_LD16  = 4'h1;
    localparam logic [3:0] OPC_LO_STA   = 4'h2;
    localparam logic [2:0] OPC_LO_DEC   = 3'd5;
    localparam logic [2:0] OPC_LO_LD8   = 3'd6;

    // Register operand codes (three-bit r8 field).
    localparam logic [2:0] R8_B   = 3'd0;
    localparam logic [2:0] R8_C   = 3'd1;
    localparam logic [2:0] R8_D   = 3'd2;
    localparam logic [2:0] R8_E   = 3'd3;
    localparam logic [2:0] R8_H   = 3'd4;
    localparam logic [2:0] R8_L   = 3'd5;
    localparam logic [2:0] R8_MEM = 3'd6;
    localparam logic [2:0] R8_A   = 3'd7;

    // Register pair codes (two-bit field at opcode bits 5:4).
    localparam logic [1:0] PAIR_BC = 2'd0;
    localparam logic [1:0] PAIR_DE = 2'd1;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    // Configuration register byte addresses.
    localparam int         CFG_ADDR_W          = 3;
    localparam logic [2:0] CFG_ADDR_START_ADDR = 3'd0;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_LD16,
        KIND_STA,
        KIND_DEC,
        KIND_LD8,
        KIND_XOR,
        KIND_JP,
        KIND_BAD
    } cise_kind_t;

    // Classified instruction as it travels through the queue.
    typedef struct packed {
        cise_kind_t  kind;
        logic [1:0]  pair;
        logic [2:0]  r8;
        logic [15:0] imm16;
        logic [7:0]  mem;
    } cise_op_t;

    // One result; the last field sits in the lowest bits.
    typedef struct packed {
        logic [1:0]  pad;
        logic        status;
        logic [7:0]  accumulator;
        logic [3:0]  flag_bits;
        logic [7:0]  write_data;
        logic [15:0] write_address;
        logic        write_valid;
        logic [15:0] hl_value;
        logic [15:0] next_pc;
    } cise_result_t;

    // Configuration write toward the execute back.
    typedef struct packed {
        logic        wr;
        logic [15:0] value;
    } cise_cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cise_front.sv
// ----------------------------------------------------------------------------
// cise_front
// Accepts instruction requests and classifies the opcode for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cise_front
    import cise_pkg::*;
(
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // opcode, imm_low, imm_high, hl_byte
    input  wire logic        q_full,
    output logic             q_push,
    output cise_op_t         q_op
);

    logic [7:0] opcode;
    logic       low_block;

    assign opcode    = s_tdata[7:0];
    assign low_block = (opcode[7:6] == 2'b00);
    assign s_tready  = !q_full;
    assign q_push    = s_tvalid && !q_full;

    always_comb
    begin
        q_op.imm16 = s_tdata[23:8];
        q_op.mem   = s_tdata[31:24];
        q_op.pair  = opcode[5:4];
        q_op.r8    = opcode[5:3];
        if (opcode == OPC_NOP)
        begin
            q_op.kind = KIND_NOP;
        end
        else if (low_block && opcode[3:0] == OPC_LO_LD16)
        begin
            q_op.kind = KIND_LD16;
        end
        else if (low_block && opcode[3:0] == OPC_LO_STA)
        begin
            q_op.kind = KIND_STA;
        end
        else if (low_block && opcode[2:0] == OPC_LO_DEC)
        begin
            q_op.kind = KIND_DEC;
        end
        else if (low_block && opcode[2:0] == OPC_LO_LD8)
        begin
            q_op.kind = KIND_LD8;
        end
        else if ((opcode & OPC_XOR_MASK) == OPC_XOR_PAT)
        begin
            // The xor source operand sits in the low three bits.
            q_op.kind = KIND_XOR;
            q_op.r8   = opcode[2:0];
        end
        else if (opcode == OPC_JP_IMM16)
        begin
            q_op.kind = KIND_JP;
        end
        else
        begin
            q_op.kind = KIND_BAD;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cise_queue.sv
// ----------------------------------------------------------------------------
// cise_queue
// Short register queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
`default_nettype none

module cise_queue
    import cise_pkg::*;
#(
    parameter int Depth = CISE_QUEUE_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire cise_op_t push_op,
    output logic          full,
    input  wire logic     pop,
    output logic          head_valid,
    output cise_op_t      head_op
);

    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);

    cise_op_t          entry_reg [Depth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CountW-1:0] count_reg, count_next;

    assign full       = (count_reg == CountW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CountW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CountW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cise_exec.sv
// ----------------------------------------------------------------------------
// cise_exec
// Executes classified instructions against the register file and
// registers one result per instruction.
// ----------------------------------------------------------------------------
`default_nettype none

module cise_exec
    import cise_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cise_cfg_t cfg,
    input  wire logic      q_valid,
    input  wire cise_op_t  q_op,
    output logic           q_pop,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output cise_result_t   m_tdata
);

    logic [7:0]   a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [7:0]   e_reg, e_next, h_reg, h_next, l_reg, l_next;
    logic [15:0]  sp_reg, sp_next, pc_reg, pc_next;
    logic [3:0]   flags_reg, flags_next;
    logic         halted_reg, halted_next;
    logic         out_valid_reg;
    cise_result_t out_reg, result_next;

    logic         load;
    logic [15:0]  hl;
    logic [7:0]   src;
    logic [7:0]   dec_val;
    logic [7:0]   xor_val;
    logic         wv;
    logic [15:0]  waddr;
    logic [7:0]   wdata;

    assign load     = q_valid && (!out_valid_reg || m_tready);
    assign q_pop    = load;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign hl       = {h_reg, l_reg};

    // Operand byte selected by the r8 field; the memory code reads hl_byte.
    always_comb
    begin
        case (q_op.r8)
            R8_B:    src = b_reg;
            R8_C:    src = c_reg;
            R8_D:    src = d_reg;
            R8_E:    src = e_reg;
            R8_H:    src = h_reg;
            R8_L:    src = l_reg;
            R8_MEM:  src = q_op.mem;
            R8_A:    src = a_reg;
            default: src = a_reg;
        endcase
    end

    assign dec_val = src - 8'd1;
    assign xor_val = a_reg ^ src;

    always_comb
    begin
        a_next      = a_reg;
        b_next      = b_reg;
        c_next      = c_reg;
        d_next      = d_reg;
        e_next      = e_reg;
        h_next      = h_reg;
        l_next      = l_reg;
        sp_next     = sp_reg;
        pc_next     = pc_reg;
        flags_next  = flags_reg;
        halted_next = halted_reg;
        wv          = 1'b0;
        waddr       = '0;
        wdata       = '0;

        if (load && !halted_reg)
        begin
            case (q_op.kind)
                KIND_NOP:
                begin
                    pc_next = pc_reg + 16'd1;
                end
                KIND_LD16:
                begin
                    case (q_op.pair)
                        PAIR_BC: {b_next, c_next} = q_op.imm16;
                        PAIR_DE: {d_next, e_next} = q_op.imm16;
                        PAIR_HL: {h_next, l_next} = q_op.imm16;
                        PAIR_SP: sp_next = q_op.imm16;
                        default: sp_next = q_op.imm16;
                    endcase
                    pc_next = pc_reg + 16'd3;
                end
                KIND_STA:
                begin
                    wv    = 1'b1;
                    wdata = a_reg;
                    case (q_op.pair)
                        PAIR_BC: waddr = {b_reg, c_reg};
                        PAIR_DE: waddr = {d_reg, e_reg};
                        PAIR_HL:
                        begin
                            waddr            = hl;
                            {h_next, l_next} = hl + 16'd1;
                        end
                        default:
                        begin
                            waddr            = hl;
                            {h_next, l_next} = hl - 16'd1;
                        end
                    endcase
                    pc_next = pc_reg + 16'd1;
                end
                KIND_DEC, KIND_LD8:
                begin
                    logic [7:0] value;
                    value = (q_op.kind == KIND_DEC) ? dec_val : q_op.imm16[7:0];
                    case (q_op.r8)
                        R8_B:   b_next = value;
                        R8_C:   c_next = value;
                        R8_D:   d_next = value;
                        R8_E:   e_next = value;
                        R8_H:   h_next = value;
                        R8_L:   l_next = value;
                        R8_MEM:
                        begin
                            wv    = 1'b1;
                            waddr = hl;
                            wdata = value;
                        end
                        default: a_next = value;
                    endcase
                    if (q_op.kind == KIND_DEC)
                    begin
                        // Z from the result, N set, H on a low-nibble borrow, C kept.
                        flags_next = {(dec_val == 8'd0), 1'b1,
                                      (dec_val[3:0] == 4'hF), flags_reg[0]};
                        pc_next    = pc_reg + 16'd1;
                    end
                    else
                    begin
                        pc_next = pc_reg + 16'd2;
                    end
                end
                KIND_XOR:
                begin
                    a_next     = xor_val;
                    flags_next = {(xor_val == 8'd0), 3'b000};
                    pc_next    = pc_reg + 16'd1;
                end
                KIND_JP:
                begin
                    pc_next = q_op.imm16;
                end
                default:
                begin
                    halted_next = 1'b1;
                end
            endcase
        end

        // A start address write reloads the program counter.
        if (cfg.wr)
        begin
            pc_next = cfg.value;
        end
    end

    always_comb
    begin
        result_next               = '0;
        result_next.next_pc       = pc_next;
        result_next.hl_value      = {h_next, l_next};
        result_next.write_valid   = wv;
        result_next.write_address = waddr;
        result_next.write_data    = wdata;
        result_next.flag_bits     = flags_next;
        result_next.accumulator   = a_next;
        result_next.status        = halted_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            e_reg         <= '0;
            h_reg         <= '0;
            l_reg         <= '0;
            sp_reg        <= '0;
            pc_reg        <= '0;
            flags_reg     <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_reg      <= a_next;
            b_reg      <= b_next;
            c_reg      <= c_next;
            d_reg      <= d_next;
            e_reg      <= e_next;
            h_reg      <= h_next;
            l_reg      <= l_next;
            sp_reg     <= sp_next;
            pc_reg     <= pc_next;
            flags_reg  <= flags_next;
            halted_reg <= halted_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result_next;
        end
    end

    // Once halted, only reset leaves the halted state.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halted mark cleared without reset");

    // The held result reports the current halted mark.
    a_status_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status == halted_reg))
        else $error("result status disagrees with halted mark");

    // A result without a memory write carries zero address and data.
    a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_reg.write_valid) |->
            (out_reg.write_address == 16'd0 && out_reg.write_data == 8'd0))
        else $error("write fields set without a write");

    // A halted block leaves the program counter alone on every item unless a start address write reloads it.
    a_halt_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (halted_reg && load && !cfg.wr) |=> (pc_reg == $past(pc_reg)))
        else $error("program counter moved while halted");

endmodule

`default_nettype wire

FILE: hw/rtl/cpu8_instruction_subset_execute.sv
// ----------------------------------------------------------------------------
// cpu8_instruction_subset_execute
// Executes one instruction of a small 8-bit CPU subset per request and
// reports the new PC, HL, flags, A, an optional memory write and a status.
// ----------------------------------------------------------------------------
// Path: an accepted request is classified into a queue entry register, and
//   the execute back takes the queue head into the result register.
// Throughput: one request per cycle while the queue is not full; the execute
//   back retires one queue entry per cycle while the result register is empty or being taken.
// Reset: rst_n clears the CPU registers, flags, SP, the halted mark, the queue
//   and the start address, so execution begins at address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8_instruction_subset_execute
    import cise_pkg::*;
#(
    parameter int QueueDepth = CISE_QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // Instruction requests.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,  // opcode, imm_low, imm_high, hl_byte
    // Results.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // next_pc, hl_value, write_valid, write_address, write_data, flag_bits,
    // accumulator, status, then two zero bits of padding.
    output logic      [71:0]           m_tdata
);

    logic         cfg_wr;
    logic [15:0]  start_address_reg;
    cise_cfg_t    cfg;
    logic         q_full;
    logic         q_push;
    cise_op_t     q_push_op;
    logic         q_pop;
    logic         q_valid;
    cise_op_t     q_head_op;
    cise_result_t result;

    // The port never waits; a write lands when the access phase is seen.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr == CFG_ADDR_START_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= '0;
        end
        else if (cfg_wr)
        begin
            start_address_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr == CFG_ADDR_START_ADDR) ? {16'd0, start_address_reg} : 32'd0;

    // Writing the start address also reloads the program counter in the back.
    assign cfg.wr    = cfg_wr;
    assign cfg.value = pwdata[15:0];

    cise_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_push_op)
    );

    cise_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_push_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head_op)
    );

    // The back owns the architectural state and the result register.
    cise_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_op     (q_head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (result)
    );

    assign m_tdata = result;

endmodule

`default_nettype wire
